@@ design/mm64_pkg.sv @@
// ----------------------------------------------------------------------------
// MurmurHash64A package
// Shared constants, types and helper functions for the string hash block.
// ----------------------------------------------------------------------------
package mm64_pkg;

   localparam int LEN_WIDTH = 32;
   localparam int WORD_WIDTH = 64;
   localparam int HALF_WIDTH = WORD_WIDTH / 2;
   localparam int CNT_WIDTH = 4;
   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 64;

   localparam logic [WORD_WIDTH-1:0] MUR_MULT = 64'hc6a4a7935bd1e995;
   localparam int MUR_SHIFT = 47;
   localparam logic [WORD_WIDTH-1:0] SEED_RESET = 64'd7;
   localparam logic [CNT_WIDTH-1:0] FULL_BYTES = 4'd8;

   localparam logic CSR_IDX_SEED = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEED,
      ST_DISPATCH,
      ST_K1,
      ST_K2,
      ST_H,
      ST_FIN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                  start;
      logic [WORD_WIDTH-1:0] op_a;
      logic [WORD_WIDTH-1:0] op_b;
   } mul_cmd_type;

   typedef struct packed {
      logic                  done;
      logic [WORD_WIDTH-1:0] product;
   } mul_rsp_type;

   function automatic logic [WORD_WIDTH-1:0] tail_mask(input logic [CNT_WIDTH-1:0] nb);
      logic [WORD_WIDTH-1:0] m;
      m = '0;
      for (int i = 0; i < 8; i++) begin
         if (CNT_WIDTH'(i) < nb) begin
            m[8*i +: 8] = 8'hff;
         end
      end
      return m;
   endfunction

   function automatic logic [WORD_WIDTH-1:0] xorshift(input logic [WORD_WIDTH-1:0] v);
      return v ^ (v >> MUR_SHIFT);
   endfunction

endpackage

@@ design/mm64_if.sv @@
// ----------------------------------------------------------------------------
// MurmurHash64A channel interfaces
// Request channel carrying message words and result channel carrying hashes.
// ----------------------------------------------------------------------------
interface mm64_req_if
   import mm64_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [WORD_WIDTH-1:0] data_word;
   logic [CNT_WIDTH-1:0]  valid_bytes;
   logic                  first_word;
   logic                  last_word;
   logic [LEN_WIDTH-1:0]  msg_len;

   modport source (output valid, data_word, valid_bytes, first_word, last_word, msg_len,
                   input ready);
   modport sink (input valid, data_word, valid_bytes, first_word, last_word, msg_len,
                 output ready);
endinterface

interface mm64_rsp_if
   import mm64_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [WORD_WIDTH-1:0] hash_value;

   modport source (output valid, hash_value, input ready);
   modport sink (input valid, hash_value, output ready);
endinterface

@@ design/mm64_mul.sv @@
// ----------------------------------------------------------------------------
// MurmurHash64A shared multiplier
// Computes the low 64 bits of a 64 x 64 product with one 32 x 32 multiplier,
// accumulating the low and the two cross partial products.
// ----------------------------------------------------------------------------
module mm64_mul
   import mm64_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mul_cmd_type cmd,
   output mul_rsp_type rsp
);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [1:0]              step_ff, step_in;
   logic [WORD_WIDTH-1:0]   a_ff, a_in;
   logic [WORD_WIDTH-1:0]   b_ff, b_in;
   logic [WORD_WIDTH-1:0]   prod_ff, prod_in;
   logic [WORD_WIDTH-1:0]   acc_ff, acc_in;
   logic [HALF_WIDTH-1:0]   mul_a;
   logic [HALF_WIDTH-1:0]   mul_b;

   always_comb begin
      mul_a = (step_ff == 2'd2) ? a_ff[WORD_WIDTH-1:HALF_WIDTH] : a_ff[HALF_WIDTH-1:0];
      mul_b = (step_ff == 2'd1) ? b_ff[WORD_WIDTH-1:HALF_WIDTH] : b_ff[HALF_WIDTH-1:0];
      prod_in = WORD_WIDTH'(mul_a) * WORD_WIDTH'(mul_b);
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      a_in = a_ff;
      b_in = b_ff;
      acc_in = acc_ff;
      if (busy_ff) begin
         step_in = step_ff + 2'd1;
         unique case (step_ff)
            2'd0: acc_in = acc_ff;
            2'd1: acc_in = prod_ff;
            2'd2, 2'd3: acc_in = {acc_ff[WORD_WIDTH-1:HALF_WIDTH] + prod_ff[HALF_WIDTH-1:0],
                                  acc_ff[HALF_WIDTH-1:0]};
            default: acc_in = acc_ff;
         endcase
         if (step_ff == 2'd3) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (cmd.start) begin
         busy_in = 1'b1;
         step_in = 2'd0;
         a_in = cmd.op_a;
         b_in = cmd.op_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      prod_ff <= prod_in;
      acc_ff <= acc_in;
   end

   assign rsp.done = done_ff;
   assign rsp.product = acc_ff;

endmodule

@@ design/mm64_csr.sv @@
// ----------------------------------------------------------------------------
// MurmurHash64A register block
// APB-style register port holding the hash seed.
// ----------------------------------------------------------------------------
module mm64_csr
   import mm64_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready,
   output logic [WORD_WIDTH-1:0]     hash_seed
);

   logic [WORD_WIDTH-1:0] seed_ff, seed_in;
   logic                  reg_idx;

   assign reg_idx = paddr[CSR_ADDR_WIDTH-1];
   assign pready = 1'b1;

   always_comb begin
      seed_in = seed_ff;
      if (psel && penable && pwrite && reg_idx == CSR_IDX_SEED) begin
         seed_in = pwdata;
      end
   end

   always_comb begin
      prdata = '0;
      if (reg_idx == CSR_IDX_SEED) begin
         prdata = seed_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= SEED_RESET;
      end else begin
         seed_ff <= seed_in;
      end
   end

   assign hash_seed = seed_ff;

endmodule

@@ design/mm64_ctrl.sv @@
// ----------------------------------------------------------------------------
// MurmurHash64A sequencer
// Takes message words, steps the hash through the shared multiplier and
// holds the finished hash in an output register.
// ----------------------------------------------------------------------------
module mm64_ctrl
   import mm64_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   mm64_req_if.sink              req,
   mm64_rsp_if.source            rsp,
   input  logic [WORD_WIDTH-1:0] hash_seed,
   output mul_cmd_type           mul_cmd,
   input  mul_rsp_type           mul_rsp
);

   state_type             state_ff, state_in;
   logic                  pend_ff, pend_in;
   logic                  in_msg_ff, in_msg_in;
   logic                  out_valid_ff, out_valid_in;
   logic [WORD_WIDTH-1:0] acc_ff, acc_in;
   logic [WORD_WIDTH-1:0] k_ff, k_in;
   logic [WORD_WIDTH-1:0] word_ff, word_in;
   logic [CNT_WIDTH-1:0]  nb_ff, nb_in;
   logic                  last_ff, last_in;
   logic [LEN_WIDTH-1:0]  len_ff, len_in;
   logic [WORD_WIDTH-1:0] out_ff, out_in;
   logic                  accept;
   logic                  mul_state;
   logic                  mul_done;

   assign accept = (state_ff == ST_IDLE) && req.valid;
   assign mul_done = pend_ff && mul_rsp.done;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               if (req.first_word) begin
                  state_in = ST_SEED;
               end else if (in_msg_ff) begin
                  state_in = ST_DISPATCH;
               end
            end
         end
         ST_SEED: begin
            if (mul_done) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            if (nb_ff == FULL_BYTES) begin
               state_in = ST_K1;
            end else if (nb_ff != '0) begin
               state_in = ST_H;
            end else begin
               state_in = last_ff ? ST_FIN : ST_IDLE;
            end
         end
         ST_K1: begin
            if (mul_done) state_in = ST_K2;
         end
         ST_K2: begin
            if (mul_done) state_in = ST_H;
         end
         ST_H: begin
            if (mul_done) state_in = last_ff ? ST_FIN : ST_IDLE;
         end
         ST_FIN: begin
            if (mul_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!out_valid_ff || rsp.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      mul_state = 1'b0;
      mul_cmd.op_a = acc_ff;
      mul_cmd.op_b = MUR_MULT;
      req.ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: req.ready = 1'b1;
         ST_SEED: begin
            mul_state = 1'b1;
            mul_cmd.op_a = WORD_WIDTH'(len_ff);
         end
         ST_K1: begin
            mul_state = 1'b1;
            mul_cmd.op_a = word_ff;
         end
         ST_K2: begin
            mul_state = 1'b1;
            mul_cmd.op_a = k_ff;
         end
         ST_H: mul_state = 1'b1;
         ST_FIN: begin
            mul_state = 1'b1;
            mul_cmd.op_a = xorshift(acc_ff);
         end
         ST_DISPATCH, ST_EMIT: mul_state = 1'b0;
         default: mul_state = 1'b0;
      endcase
      mul_cmd.start = mul_state && !pend_ff;
      rsp.valid = out_valid_ff;
      rsp.hash_value = out_ff;
   end

   always_comb begin
      pend_in = pend_ff;
      if (mul_cmd.start) begin
         pend_in = 1'b1;
      end else if (mul_rsp.done) begin
         pend_in = 1'b0;
      end

      word_in = word_ff;
      nb_in = nb_ff;
      last_in = last_ff;
      len_in = len_ff;
      in_msg_in = in_msg_ff;
      if (accept) begin
         word_in = req.data_word;
         nb_in = (req.valid_bytes > FULL_BYTES) ? FULL_BYTES : req.valid_bytes;
         last_in = req.last_word;
         len_in = req.msg_len;
         in_msg_in = (req.first_word || in_msg_ff) && !req.last_word;
      end

      acc_in = acc_ff;
      k_in = k_ff;
      unique case (state_ff)
         ST_SEED: if (mul_done) acc_in = hash_seed ^ mul_rsp.product;
         ST_DISPATCH: begin
            if (nb_ff != FULL_BYTES && nb_ff != '0) begin
               acc_in = acc_ff ^ (word_ff & tail_mask(nb_ff));
            end
         end
         ST_K1: if (mul_done) k_in = xorshift(mul_rsp.product);
         ST_K2: if (mul_done) acc_in = acc_ff ^ mul_rsp.product;
         ST_H: if (mul_done) acc_in = mul_rsp.product;
         ST_FIN: if (mul_done) k_in = xorshift(mul_rsp.product);
         ST_IDLE, ST_EMIT: acc_in = acc_ff;
         default: acc_in = acc_ff;
      endcase

      out_valid_in = out_valid_ff;
      out_in = out_ff;
      if (out_valid_ff && rsp.ready) begin
         out_valid_in = 1'b0;
      end
      if (state_ff == ST_EMIT && (!out_valid_ff || rsp.ready)) begin
         out_valid_in = 1'b1;
         out_in = k_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff <= 1'b0;
         in_msg_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         acc_ff <= '0;
      end else begin
         state_ff <= state_in;
         pend_ff <= pend_in;
         in_msg_ff <= in_msg_in;
         out_valid_ff <= out_valid_in;
         acc_ff <= acc_in;
      end
      k_ff <= k_in;
      word_ff <= word_in;
      nb_ff <= nb_in;
      last_ff <= last_in;
      len_ff <= len_in;
      out_ff <= out_in;
   end

endmodule

@@ design/murmur64a_string_hash.sv @@
// ----------------------------------------------------------------------------
// MurmurHash64A string hash
// Top level: register port, sequencer and shared multiplier.
// ----------------------------------------------------------------------------
// One word is taken at a time and the block is not ready until its work is
// done. Each 64-bit multiply runs on the shared 32 x 32 multiplier, and a
// word also passes through transfer and dispatch: a full word needs three
// multiplies, a partial word one, and a first word adds one multiply for the
// seed. The last word adds one more multiply for finalization, after which
// the result register is loaded. The result register holds the hash until
// its transfer, while the next message is already being taken in.
module murmur64a_string_hash
   import mm64_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   mm64_req_if.sink                  req,
   mm64_rsp_if.source                rsp,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   logic [WORD_WIDTH-1:0] hash_seed;
   mul_cmd_type           mul_cmd;
   mul_rsp_type           mul_rsp;

   mm64_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (csr_psel),
      .penable   (csr_penable),
      .pwrite    (csr_pwrite),
      .paddr     (csr_paddr),
      .pwdata    (csr_pwdata),
      .prdata    (csr_prdata),
      .pready    (csr_pready),
      .hash_seed (hash_seed)
   );

   mm64_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp       (rsp),
      .hash_seed (hash_seed),
      .mul_cmd   (mul_cmd),
      .mul_rsp   (mul_rsp)
   );

   mm64_mul u_mul (
      .clock (clock),
      .reset (reset),
      .cmd   (mul_cmd),
      .rsp   (mul_rsp)
   );

endmodule

@@ design/mm64_checker.sv @@
// ----------------------------------------------------------------------------
// MurmurHash64A port checker
// Checks port behavior of the string hash over time.
// ----------------------------------------------------------------------------
module mm64_checker
   import mm64_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  req_first_word,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [WORD_WIDTH-1:0] rsp_hash_value
);

   a_rsp_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hash_value))
      else $error("stalled result changed");

   a_first_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_first_word |-> ##4 !req_ready)
      else $error("block ready too early after a first word");

   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared while the block was idle");

endmodule

bind murmur64a_string_hash mm64_checker u_mm64_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req.valid),
   .req_ready      (req.ready),
   .req_first_word (req.first_word),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_hash_value (rsp.hash_value)
);
